FILE: hdl/srg_pkg.sv
// Shared types and constants for the sensor report gate.
package srg_pkg;

    localparam int TEMP_W    = 16;
    localparam int HUMI_W    = 14;
    localparam int MV_W      = 13;
    localparam int PCT_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int LEVEL_W   = 2;
    localparam int CNT16_W   = 16;
    localparam int CNT18_W   = 18;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOREPORT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REPORT   = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MED  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_REPORT_TEMP_DELTA   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPORT_HUMI_DELTA   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FORCE_INTERVAL      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECAL_TEMP_DELTA    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECAL_PERIOD        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BATTERY_INTERVAL    = 3'd5;

    localparam logic [15:0] RST_REPORT_TEMP_DELTA = 16'd50;
    localparam logic [15:0] RST_REPORT_HUMI_DELTA = 16'd100;
    localparam logic [15:0] RST_FORCE_INTERVAL    = 16'd60;
    localparam logic [15:0] RST_RECAL_TEMP_DELTA  = 16'd1550;
    localparam logic [17:0] RST_RECAL_PERIOD      = 18'd120960;
    localparam logic [15:0] RST_BATTERY_INTERVAL  = 16'd4320;

    localparam logic signed [15:0] RST_LAST_REPORTED = -16'sd9900;
    localparam logic [MV_W-1:0]    RST_BATTERY_MV    = 13'd3000;

    localparam logic [CNT16_W-1:0] COUNT16_MAX = 16'hFFFF;
    localparam logic [CNT18_W-1:0] COUNT18_MAX = 18'h3FFFF;

    localparam logic [MV_W-1:0] BAT_FULL_MV    = 13'd3000;
    localparam logic [MV_W-1:0] BAT_HIGH_MV    = 13'd2900;
    localparam logic [MV_W-1:0] BAT_MID_MV     = 13'd2800;
    localparam logic [MV_W-1:0] BAT_LOWMID_MV  = 13'd2700;
    localparam logic [MV_W-1:0] BAT_EMPTY_MV   = 13'd2500;
    localparam logic [MV_W-1:0] LEVEL_HIGH_MV  = 13'd2900;
    localparam logic [MV_W-1:0] LEVEL_MED_MV   = 13'd2600;

    // classified item passed from front to back
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   recalibrate;
        logic signed [TEMP_W-1:0] report_temp;
        logic [HUMI_W-1:0]      report_humi;
        logic [MV_W-1:0]        battery_mv;
    } srg_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } srg_queue_status_t;

endpackage

FILE: hdl/srg_front.sv
// Front end: configuration registers, report/recalibration decisions, battery latch.
module srg_front
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [srg_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [srg_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                                   accept,
    input  logic signed [srg_pkg::TEMP_W-1:0]      temp_centi,
    input  logic [srg_pkg::HUMI_W-1:0]             humi_centi,
    input  logic                                   meas_valid,
    input  logic [srg_pkg::MV_W-1:0]               vbat_reading,
    output srg_pkg::srg_item_t                     item
);

    logic [15:0] report_temp_delta_reg;
    logic [15:0] report_humi_delta_reg;
    logic [15:0] force_interval_reg;
    logic [15:0] recal_temp_delta_reg;
    logic [17:0] recal_period_reg;
    logic [15:0] battery_interval_reg;

    logic signed [15:0]              last_temp_reg, last_temp_next;
    logic signed [15:0]              last_humi_reg, last_humi_next;
    logic [srg_pkg::CNT16_W-1:0]     force_count_reg, force_count_next;
    logic [srg_pkg::CNT16_W-1:0]     bat_count_reg, bat_count_next;
    logic [srg_pkg::MV_W-1:0]        bat_mv_reg, bat_mv_next;
    logic                            recal_started_reg, recal_started_next;
    logic signed [15:0]              recal_base_reg, recal_base_next;
    logic [srg_pkg::CNT18_W-1:0]     recal_count_reg, recal_count_next;

    logic [16:0]                 bat_count_inc;
    logic [srg_pkg::CNT16_W-1:0] force_count_inc;
    logic [srg_pkg::CNT18_W-1:0] recal_count_inc;
    logic [16:0]                 base_diff;
    logic [16:0]                 temp_diff;
    logic [16:0]                 humi_diff;
    logic                        recal_hit;
    logic                        report;

    function automatic logic [16:0] abs_diff(input logic signed [16:0] a,
                                             input logic signed [16:0] b);
        logic signed [16:0] d;
        begin
            d = a - b;
            abs_diff = d[16] ? 17'(-d) : 17'(d);
        end
    endfunction

    always_comb
    begin
        bat_count_inc   = {1'b0, bat_count_reg} + 17'd1;
        force_count_inc = (force_count_reg != srg_pkg::COUNT16_MAX) ?
                          force_count_reg + 16'd1 : force_count_reg;
        recal_count_inc = (recal_count_reg != srg_pkg::COUNT18_MAX) ?
                          recal_count_reg + 18'd1 : recal_count_reg;

        base_diff = abs_diff({temp_centi[15], temp_centi}, {recal_base_reg[15], recal_base_reg});
        temp_diff = abs_diff({temp_centi[15], temp_centi}, {last_temp_reg[15], last_temp_reg});
        humi_diff = abs_diff({3'b000, humi_centi}, {last_humi_reg[15], last_humi_reg});

        recal_hit = recal_started_reg &&
                    ((base_diff >= {1'b0, recal_temp_delta_reg}) ||
                     (recal_count_inc >= recal_period_reg));
        report = (temp_diff >= {1'b0, report_temp_delta_reg}) ||
                 (humi_diff >= {1'b0, report_humi_delta_reg}) ||
                 (force_count_inc >= force_interval_reg);

        bat_mv_next    = (bat_count_reg == '0) ? vbat_reading : bat_mv_reg;
        bat_count_next = ((bat_count_inc >= {1'b0, battery_interval_reg}) || bat_count_inc[16]) ?
                         '0 : bat_count_inc[15:0];

        recal_started_next = recal_started_reg;
        recal_base_next    = recal_base_reg;
        recal_count_next   = recal_count_reg;
        last_temp_next     = last_temp_reg;
        last_humi_next     = last_humi_reg;
        force_count_next   = force_count_inc;

        if (meas_valid)
        begin
            if (!recal_started_reg)
            begin
                recal_started_next = 1'b1;
                recal_base_next    = temp_centi;
            end
            else
            begin
                recal_count_next = recal_hit ? '0 : recal_count_inc;
                recal_base_next  = recal_hit ? temp_centi : recal_base_reg;
            end
            if (report)
            begin
                last_temp_next   = temp_centi;
                last_humi_next   = {2'b00, humi_centi};
                force_count_next = '0;
            end
        end

        if (!meas_valid)
            item.status = srg_pkg::STATUS_INVALID;
        else if (report)
            item.status = srg_pkg::STATUS_REPORT;
        else
            item.status = srg_pkg::STATUS_NOREPORT;
        item.recalibrate = meas_valid && recal_hit;
        item.report_temp = (meas_valid && report) ? temp_centi : '0;
        item.report_humi = (meas_valid && report) ? humi_centi : '0;
        item.battery_mv  = bat_mv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_temp_delta_reg <= srg_pkg::RST_REPORT_TEMP_DELTA;
            report_humi_delta_reg <= srg_pkg::RST_REPORT_HUMI_DELTA;
            force_interval_reg    <= srg_pkg::RST_FORCE_INTERVAL;
            recal_temp_delta_reg  <= srg_pkg::RST_RECAL_TEMP_DELTA;
            recal_period_reg      <= srg_pkg::RST_RECAL_PERIOD;
            battery_interval_reg  <= srg_pkg::RST_BATTERY_INTERVAL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                srg_pkg::CFG_REPORT_TEMP_DELTA: report_temp_delta_reg <= cfg_wdata[15:0];
                srg_pkg::CFG_REPORT_HUMI_DELTA: report_humi_delta_reg <= cfg_wdata[15:0];
                srg_pkg::CFG_FORCE_INTERVAL:    force_interval_reg    <= cfg_wdata[15:0];
                srg_pkg::CFG_RECAL_TEMP_DELTA:  recal_temp_delta_reg  <= cfg_wdata[15:0];
                srg_pkg::CFG_RECAL_PERIOD:      recal_period_reg      <= cfg_wdata;
                srg_pkg::CFG_BATTERY_INTERVAL:  battery_interval_reg  <= cfg_wdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_temp_reg     <= srg_pkg::RST_LAST_REPORTED;
            last_humi_reg     <= srg_pkg::RST_LAST_REPORTED;
            force_count_reg   <= '0;
            bat_count_reg     <= '0;
            bat_mv_reg        <= srg_pkg::RST_BATTERY_MV;
            recal_started_reg <= 1'b0;
            recal_base_reg    <= '0;
            recal_count_reg   <= '0;
        end
        else if (accept)
        begin
            last_temp_reg     <= last_temp_next;
            last_humi_reg     <= last_humi_next;
            force_count_reg   <= force_count_next;
            bat_count_reg     <= bat_count_next;
            bat_mv_reg        <= bat_mv_next;
            recal_started_reg <= recal_started_next;
            recal_base_reg    <= recal_base_next;
            recal_count_reg   <= recal_count_next;
        end
    end

    a_report_clears_force: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.status == srg_pkg::STATUS_REPORT |=> force_count_reg == '0)
        else $error("force count not cleared after report");

    a_recal_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.recalibrate |=> recal_count_reg == '0 && recal_started_reg)
        else $error("recal count not cleared after recalibration");

endmodule

FILE: hdl/srg_queue.sv
// Short item queue between front and back.
module srg_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  srg_pkg::srg_item_t         push_item,
    input  logic                       pop,
    output srg_pkg::srg_item_t         head_item,
    output srg_pkg::srg_queue_status_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    srg_pkg::srg_item_t entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
        qstat.empty = (count_reg == '0);
        qstat.full  = (count_reg == CNT_W'(DEPTH));
        head_item   = entries_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full && !pop |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.empty |-> !pop)
        else $error("pop from empty queue");

endmodule

FILE: hdl/srg_back.sv
// Back end: battery grading, percentage and the output register.
module srg_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  srg_pkg::srg_queue_status_t    qstat,
    input  srg_pkg::srg_item_t            head_item,
    output logic                          pop,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [srg_pkg::STATUS_W-1:0]  status,
    output logic                          recalibrate,
    output logic [srg_pkg::LEVEL_W-1:0]   battery_level,
    output logic [srg_pkg::PCT_W-1:0]     battery_percent,
    output logic signed [srg_pkg::TEMP_W-1:0] report_temp,
    output logic [srg_pkg::HUMI_W-1:0]    report_humi,
    output logic [srg_pkg::MV_W-1:0]      battery_mv
);

    logic                          out_valid_reg, out_valid_next;
    srg_pkg::srg_item_t            out_item_reg;
    logic [srg_pkg::LEVEL_W-1:0]   level_reg, level_next;
    logic [srg_pkg::PCT_W-1:0]     pct_reg, pct_next;

    logic [srg_pkg::MV_W-1:0] mv;
    logic [7:0]               span;
    logic [17:0]              prod;

    // x/10 as (x*205)>>11, exact for x below 1029
    always_comb
    begin
        mv   = head_item.battery_mv;
        span = '0;
        prod = '0;
        pct_next = '0;
        priority if (mv >= srg_pkg::BAT_FULL_MV)
            pct_next = 7'd100;
        else if (mv >= srg_pkg::BAT_HIGH_MV)
        begin
            span = 8'(mv - srg_pkg::BAT_HIGH_MV);
            prod = 18'({10'd0, span} * 18'd205);
            pct_next = 7'd80 + 7'(prod >> 10);
        end
        else if (mv >= srg_pkg::BAT_MID_MV)
        begin
            span = 8'(mv - srg_pkg::BAT_MID_MV);
            prod = 18'({10'd0, span} * 18'd615);
            pct_next = 7'd50 + 7'(prod >> 11);
        end
        else if (mv >= srg_pkg::BAT_LOWMID_MV)
        begin
            span = 8'(mv - srg_pkg::BAT_LOWMID_MV);
            prod = 18'({10'd0, span} * 18'd615);
            pct_next = 7'd20 + 7'(prod >> 11);
        end
        else if (mv >= srg_pkg::BAT_EMPTY_MV)
        begin
            span = 8'(mv - srg_pkg::BAT_EMPTY_MV);
            prod = 18'({10'd0, span} * 18'd205);
            pct_next = 7'(prod >> 11);
        end
        else
            pct_next = '0;

        priority if (mv > srg_pkg::LEVEL_HIGH_MV)
            level_next = srg_pkg::LEVEL_HIGH;
        else if (mv > srg_pkg::LEVEL_MED_MV)
            level_next = srg_pkg::LEVEL_MED;
        else
            level_next = srg_pkg::LEVEL_LOW;

        pop = !qstat.empty && (!out_valid_reg || out_ready);
        out_valid_next = pop || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= head_item;
            level_reg    <= level_next;
            pct_reg      <= pct_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_item_reg.status;
    assign recalibrate     = out_item_reg.recalibrate;
    assign battery_level   = level_reg;
    assign battery_percent = pct_reg;
    assign report_temp     = out_item_reg.report_temp;
    assign report_humi     = out_item_reg.report_humi;
    assign battery_mv      = out_item_reg.battery_mv;

    a_held_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("output item lost before handshake");

endmodule

FILE: hdl/sensor_report_gate_unit.sv
// Accepted items are queued and enter the output register if it is empty or m_tready is high.
// Throughput: one item per cycle while s_tready is high; the front updates all gate state in
// the accept cycle. With m_tready low, input flows until the queue (depth 2 by default) is full.
// Reset (rst_n low, asynchronous) restores register defaults and the gate state, empties
// the queue and drops m_tvalid; the first cycle after reset can accept an item.
module sensor_report_gate_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [17:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // temp_centi[15:0], humi_centi[29:16], vbat_reading[42:30]
    input  logic        s_tuser,   // meas_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // recalibrate[0], battery_level[2:1], battery_percent[9:3],
                                   // report_temp[25:10], report_humi[39:26], battery_mv[52:40]
    output logic [1:0]  m_tuser    // status
);

    logic                       accept;
    logic                       pop;
    srg_pkg::srg_item_t         front_item;
    srg_pkg::srg_item_t         head_item;
    srg_pkg::srg_queue_status_t qstat;

    logic [srg_pkg::STATUS_W-1:0]      status;
    logic                              recalibrate;
    logic [srg_pkg::LEVEL_W-1:0]       battery_level;
    logic [srg_pkg::PCT_W-1:0]         battery_percent;
    logic signed [srg_pkg::TEMP_W-1:0] report_temp;
    logic [srg_pkg::HUMI_W-1:0]        report_humi;
    logic [srg_pkg::MV_W-1:0]          battery_mv;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;

    srg_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .accept       (accept),
        .temp_centi   (s_tdata[15:0]),
        .humi_centi   (s_tdata[29:16]),
        .meas_valid   (s_tuser),
        .vbat_reading (s_tdata[42:30]),
        .item         (front_item)
    );

    srg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    srg_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .qstat           (qstat),
        .head_item       (head_item),
        .pop             (pop),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .status          (status),
        .recalibrate     (recalibrate),
        .battery_level   (battery_level),
        .battery_percent (battery_percent),
        .report_temp     (report_temp),
        .report_humi     (report_humi),
        .battery_mv      (battery_mv)
    );

    assign m_tuser = status;
    assign m_tdata = {3'b000, battery_mv, report_humi, report_temp, battery_percent,
                      battery_level, recalibrate};

endmodule

FILE: test/tb_sensor_report_gate_unit.sv
// Testbench for sensor_report_gate_unit: stream stimulus, register phases and result scoreboard.
module tb_sensor_report_gate_unit;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_PRINTS     = 60;
    localparam int PHASE_ITEMS    = 40;
    localparam int IDLE_RUN_ITEMS = 32;

    localparam logic [srg_pkg::CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [srg_pkg::CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_mode_t;

    typedef struct {
        logic [srg_pkg::STATUS_W-1:0]      status;
        logic                              recalibrate;
        logic [srg_pkg::LEVEL_W-1:0]       level;
        logic [srg_pkg::PCT_W-1:0]         percent;
        logic signed [srg_pkg::TEMP_W-1:0] report_temp;
        logic [srg_pkg::HUMI_W-1:0]        report_humi;
        logic [srg_pkg::MV_W-1:0]          battery_mv;
    } gate_result_t;

    class gate_scoreboard;
        int unsigned rep_temp_delta;
        int unsigned rep_humi_delta;
        int unsigned force_interval;
        int unsigned recal_delta;
        int unsigned recal_period;
        int unsigned bat_interval;
        int          last_temp;
        int          last_humi;
        int          recal_base;
        bit          recal_started;
        int unsigned force_count;
        int unsigned bat_count;
        int unsigned recal_count;
        int unsigned latched_mv;
        gate_result_t expected_q[$];
        int errors;

        function new();
            errors = 0;
            rep_temp_delta = 32'(srg_pkg::RST_REPORT_TEMP_DELTA);
            rep_humi_delta = 32'(srg_pkg::RST_REPORT_HUMI_DELTA);
            force_interval = 32'(srg_pkg::RST_FORCE_INTERVAL);
            recal_delta    = 32'(srg_pkg::RST_RECAL_TEMP_DELTA);
            recal_period   = 32'(srg_pkg::RST_RECAL_PERIOD);
            bat_interval   = 32'(srg_pkg::RST_BATTERY_INTERVAL);
            last_temp      = int'(srg_pkg::RST_LAST_REPORTED);
            last_humi      = int'(srg_pkg::RST_LAST_REPORTED);
            recal_base     = 0;
            recal_started  = 1'b0;
            force_count    = 0;
            bat_count      = 0;
            recal_count    = 0;
            latched_mv     = 32'(srg_pkg::RST_BATTERY_MV);
        endfunction

        function void write_reg(logic [srg_pkg::CFG_ADDR_W-1:0] idx,
                                logic [srg_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                srg_pkg::CFG_REPORT_TEMP_DELTA: rep_temp_delta = 32'(val[15:0]);
                srg_pkg::CFG_REPORT_HUMI_DELTA: rep_humi_delta = 32'(val[15:0]);
                srg_pkg::CFG_FORCE_INTERVAL:    force_interval = 32'(val[15:0]);
                srg_pkg::CFG_RECAL_TEMP_DELTA:  recal_delta    = 32'(val[15:0]);
                srg_pkg::CFG_RECAL_PERIOD:      recal_period   = 32'(val);
                srg_pkg::CFG_BATTERY_INTERVAL:  bat_interval   = 32'(val[15:0]);
                default: ;
            endcase
        endfunction

        function int unsigned gap_between(int a, int b);
            return (a >= b) ? a - b : b - a;
        endfunction

        function int unsigned battery_percent(int unsigned mv);
            if (mv >= srg_pkg::BAT_FULL_MV)   return 100;
            if (mv >= srg_pkg::BAT_HIGH_MV)   return 80 + (mv - srg_pkg::BAT_HIGH_MV) / 5;
            if (mv >= srg_pkg::BAT_MID_MV)    return 50 + (mv - srg_pkg::BAT_MID_MV) * 3 / 10;
            if (mv >= srg_pkg::BAT_LOWMID_MV) return 20 + (mv - srg_pkg::BAT_LOWMID_MV) * 3 / 10;
            if (mv >= srg_pkg::BAT_EMPTY_MV)  return (mv - srg_pkg::BAT_EMPTY_MV) / 10;
            return 0;
        endfunction

        function void note_item(logic signed [srg_pkg::TEMP_W-1:0] temp,
                                logic [srg_pkg::HUMI_W-1:0] humi,
                                logic ok, logic [srg_pkg::MV_W-1:0] vbat);
            gate_result_t r;
            int t;
            int h;
            bit fire;
            t = int'(temp);
            h = int'(humi);
            r.status      = srg_pkg::STATUS_INVALID;
            r.recalibrate = 1'b0;
            r.report_temp = '0;
            r.report_humi = '0;

            // latch lands before grading
            if (bat_count == 0)
                latched_mv = 32'(vbat);
            bat_count++;
            if (bat_count >= bat_interval || bat_count > srg_pkg::COUNT16_MAX)
                bat_count = 0;

            if (force_count < srg_pkg::COUNT16_MAX)
                force_count++;

            if (ok)
            begin
                if (!recal_started)
                begin
                    recal_base    = t;
                    recal_started = 1'b1;
                end
                else
                begin
                    if (recal_count < srg_pkg::COUNT18_MAX)
                        recal_count++;
                    if (gap_between(t, recal_base) >= recal_delta || recal_count >= recal_period)
                    begin
                        r.recalibrate = 1'b1;
                        recal_base    = t;
                        recal_count   = 0;
                    end
                end
                fire = gap_between(t, last_temp) >= rep_temp_delta
                    || gap_between(h, last_humi) >= rep_humi_delta
                    || force_count >= force_interval;
                if (fire)
                begin
                    last_temp     = t;
                    last_humi     = h;
                    force_count   = 0;
                    r.status      = srg_pkg::STATUS_REPORT;
                    r.report_temp = temp;
                    r.report_humi = humi;
                end
                else
                begin
                    r.status = srg_pkg::STATUS_NOREPORT;
                end
            end

            if (latched_mv > srg_pkg::LEVEL_HIGH_MV)
                r.level = srg_pkg::LEVEL_HIGH;
            else if (latched_mv > srg_pkg::LEVEL_MED_MV)
                r.level = srg_pkg::LEVEL_MED;
            else
                r.level = srg_pkg::LEVEL_LOW;
            r.percent    = 7'(battery_percent(latched_mv));
            r.battery_mv = 13'(latched_mv);
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("%0t: %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(logic [55:0] data, logic [1:0] user);
            gate_result_t e;
            if (expected_q.size() == 0)
            begin
                report("result with no item outstanding");
                return;
            end
            e = expected_q.pop_front();
            compare_field("status", 32'(user), 32'(e.status));
            compare_field("recalibrate", 32'(data[0]), 32'(e.recalibrate));
            compare_field("battery_level", 32'(data[2:1]), 32'(e.level));
            compare_field("battery_percent", 32'(data[9:3]), 32'(e.percent));
            compare_field("report_temp", 32'(data[25:10]), 32'($unsigned(e.report_temp)));
            compare_field("report_humi", 32'(data[39:26]), 32'(e.report_humi));
            compare_field("battery_mv", 32'(data[52:40]), 32'(e.battery_mv));
            compare_field("pad bits", 32'(data[55:53]), 32'd0);
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [srg_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [srg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [47:0]                    s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [55:0]                    m_tdata;
    logic [1:0]                     m_tuser;

    gate_scoreboard     sb;
    flow_mode_t         flow = FLOW_FREE;
    int                 hold_token = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;
    int                 stuck_cycles = 0;
    logic signed [15:0] temp_center = 16'sd2000;
    int                 humi_center = 5000;
    logic [12:0]        vbat_points [16] = '{13'd0, 13'd2499, 13'd2500, 13'd2509, 13'd2600,
                                             13'd2601, 13'd2699, 13'd2700, 13'd2799, 13'd2800,
                                             13'd2899, 13'd2900, 13'd2901, 13'd2999, 13'd3000,
                                             13'd8191};

    sensor_report_gate_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 clk = ~clk;

    function automatic int src_gap_pct(flow_mode_t m);
        case (m)
            FLOW_SRC_IDLE: return 80;
            FLOW_BOTH:     return 33;
            default:       return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct(flow_mode_t m);
        case (m)
            FLOW_SINK_STALL: return 80;
            FLOW_BOTH:       return 33;
            default:         return 0;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_item(s_tdata[15:0], s_tdata[29:16], s_tuser, s_tdata[42:30]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // sink: long hold-off on request, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct(flow));
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input logic signed [15:0] temp, input logic [13:0] humi,
                             input logic ok, input logic [12:0] vbat);
        int pct;
        pct = src_gap_pct(flow);
        if (pct > 0 && $urandom_range(99) < pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, vbat, humi, temp};
        s_tuser  <= ok;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_random();
        int          step;
        int          h;
        logic        ok;
        logic [12:0] v;
        case ($urandom_range(3))
            0:       step = 30;
            1:       step = 300;
            2:       step = 3000;
            default: step = 100;
        endcase
        if ($urandom_range(9) == 0)
            temp_center = 16'($urandom);
        else
            temp_center = temp_center + 16'(int'($urandom_range(2 * step)) - step);
        humi_center = humi_center + int'($urandom_range(2 * step)) - step;
        if (humi_center < 0)
            humi_center = 0;
        if (humi_center > 10000)
            humi_center = 10000;
        h  = ($urandom_range(19) == 0) ? int'($urandom_range(16383)) : humi_center;
        ok = ($urandom_range(99) < 85);
        v  = ($urandom_range(9) < 7) ? 13'($urandom_range(3100, 2400))
                                     : 13'($urandom_range(8191));
        send_item(temp_center, 14'(h), ok, v);
    endtask

    // wait until every item has come back out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [srg_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [srg_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic configure(input logic [17:0] rtd, input logic [17:0] rhd,
                             input logic [17:0] fint, input logic [17:0] rcd,
                             input logic [17:0] rper, input logic [17:0] bint);
        write_reg(srg_pkg::CFG_REPORT_TEMP_DELTA, rtd);
        write_reg(srg_pkg::CFG_REPORT_HUMI_DELTA, rhd);
        write_reg(srg_pkg::CFG_FORCE_INTERVAL, fint);
        write_reg(srg_pkg::CFG_RECAL_TEMP_DELTA, rcd);
        write_reg(srg_pkg::CFG_RECAL_PERIOD, rper);
        write_reg(srg_pkg::CFG_BATTERY_INTERVAL, bint);
        write_reg(CFG_SPARE_LO, 18'($urandom));
        write_reg(CFG_SPARE_HI, 18'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        send_item(16'sd2000, 14'd5000, 1'b1, 13'd2550);
        send_item(16'sd2049, 14'd5099, 1'b1, 13'd8191);
        send_item(16'sd2050, 14'd5099, 1'b1, 13'd0);
        send_item(16'sd2050, 14'd5200, 1'b1, 13'd0);
        send_item(-16'sd1234, 14'd777, 1'b0, 13'd8191);
        send_item(16'sh7FFF, 14'd10000, 1'b1, 13'd1234);
        send_item(16'sh8000, 14'd0, 1'b1, 13'd4000);
        send_item(16'sh8000, 14'h3FFF, 1'b1, 13'd2000);
        drain();

        // battery latched on every item: walk the grading breakpoints
        configure(18'd1000, 18'd1000, 18'd3, 18'd1550, 18'd2, 18'd1);
        foreach (vbat_points[i])
            send_item(16'sd100, 14'd4000, 1'($urandom_range(1)), vbat_points[i]);

        for (int p = 0; p < 8; p++)
        begin
            drain();
            case (p)
                0: configure(18'd20, 18'd40, 18'd5, 18'd300, 18'd7, 18'd3);
                1: configure(18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0);
                2: configure(18'd65535, 18'd65535, 18'd65535, 18'd65535, 18'd262143, 18'd65535);
                3: configure(18'h20019, 18'h10032, 18'h30004, 18'h200C8, 18'd3, 18'h10002);
                4: configure(18'd1, 18'd1, 18'd1, 18'd1, 18'd1, 18'd1);
                5: configure(18'd200, 18'd300, 18'd10, 18'd800, 18'd20, 18'd1);
                6: configure(18'(srg_pkg::RST_REPORT_TEMP_DELTA),
                             18'(srg_pkg::RST_REPORT_HUMI_DELTA),
                             18'(srg_pkg::RST_FORCE_INTERVAL),
                             18'(srg_pkg::RST_RECAL_TEMP_DELTA),
                             srg_pkg::RST_RECAL_PERIOD, 18'd4);
                default: configure(18'($urandom_range(500)), 18'($urandom_range(500)),
                                   18'($urandom_range(12)), 18'($urandom_range(3000)),
                                   18'($urandom_range(30)), 18'($urandom_range(5)));
            endcase
            flow = flow_mode_t'(p % 4);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                    flow = flow_mode_t'((p + 1) % 4);
                send_random();
            end
        end

        // sink holds off while the source keeps offering
        drain();
        configure(18'd100, 18'd100, 18'd8, 18'd500, 18'd10, 18'd2);
        flow = FLOW_FREE;
        hold_token++;
        repeat (40) send_random();

        // invalid items run force_count past its interval, then valid items report
        drain();
        configure(18'd65535, 18'd65535, 18'd30, 18'd65535, 18'd262143, 18'd65535);
        repeat (IDLE_RUN_ITEMS)
            send_item(16'($urandom), 14'($urandom), 1'b0, 13'($urandom));
        repeat (3)
            send_item(16'($urandom), 14'($urandom_range(10000)), 1'b1, 13'($urandom));

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/srg_pkg.sv
hdl/srg_front.sv
hdl/srg_queue.sv
hdl/srg_back.sv
hdl/sensor_report_gate_unit.sv
test/tb_sensor_report_gate_unit.sv
